FILE: hdl/frgcd_pkg.sv
// Shared types and constants for the binary GCD fraction reducer.
// Holds the microcode word layout, datapath operations and step addresses.
// No dependencies.
package frgcd_pkg;

    localparam int WORD_BITS  = 32;
    localparam int SHIFT_BITS = $clog2(WORD_BITS);
    localparam int CNT_BITS   = $clog2(WORD_BITS + 1);
    localparam int STEP_BITS  = 4;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [STEP_BITS-1:0] step_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_G_FROM_U,
        OP_G_FROM_V,
        OP_HALVE_BOTH,
        OP_HALVE_U,
        OP_HALVE_V,
        OP_SUB,
        OP_G_SHIFT,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_EMIT,
        OP_UNDEF
    } op_t;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_NO_IN,
        C_BOTH_ZERO,
        C_U_ZERO,
        C_V_ZERO,
        C_BOTH_EVEN,
        C_U_EVEN,
        C_V_EVEN,
        C_SUB_MORE,
        C_DIV_MORE,
        C_OUT_BUSY
    } cond_t;

    // When the step's operation fires relative to its jump condition
    typedef enum logic [1:0] {
        EX_ALWAYS,
        EX_TAKEN,
        EX_NOT_TAKEN
    } exec_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        exec_t exec;
        step_t target;
    } uword_t;

    typedef struct packed {
        logic both_zero;
        logic u_zero;
        logic v_zero;
        logic both_even;
        logic u_even;
        logic v_even;
        logic sub_more;
        logic div_more;
        logic out_busy;
    } dp_status_t;

    localparam step_t STEP_IDLE      = 4'd0;
    localparam step_t STEP_CHK_BOTH  = 4'd1;
    localparam step_t STEP_CHK_U     = 4'd2;
    localparam step_t STEP_CHK_V     = 4'd3;
    localparam step_t STEP_STRIP     = 4'd4;
    localparam step_t STEP_ODD_U     = 4'd5;
    localparam step_t STEP_ODD_V     = 4'd6;
    localparam step_t STEP_SUB       = 4'd7;
    localparam step_t STEP_G_SHIFT   = 4'd8;
    localparam step_t STEP_DIV_INIT  = 4'd9;
    localparam step_t STEP_DIV_LOOP  = 4'd10;
    localparam step_t STEP_EMIT      = 4'd11;
    localparam step_t STEP_RETURN    = 4'd12;
    localparam step_t STEP_UNDEF     = 4'd13;

endpackage

FILE: hdl/frgcd_if.sv
// Valid/ready channel interfaces for the fraction reducer input and result.
// Depends on frgcd_pkg for the word type.
interface frgcd_in_if;
    logic              valid;
    logic              ready;
    frgcd_pkg::word_t  numerator;
    frgcd_pkg::word_t  denominator;

    modport source (output valid, output numerator, output denominator, input ready);
    modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

interface frgcd_out_if;
    logic              valid;
    logic              ready;
    frgcd_pkg::word_t  reduced_numerator;
    frgcd_pkg::word_t  reduced_denominator;
    frgcd_pkg::word_t  common_divisor;
    logic              undefined_flag;

    modport source (output valid, output reduced_numerator, output reduced_denominator,
                    output common_divisor, output undefined_flag, input ready);
    modport sink   (input valid, input reduced_numerator, input reduced_denominator,
                    input common_divisor, input undefined_flag, output ready);
endinterface

FILE: hdl/frgcd_rom.sv
// Microcode store: one control word per sequencer step.
// Depends on frgcd_pkg for the word layout and step addresses.
module frgcd_rom (
    input  frgcd_pkg::step_t  addr,
    output frgcd_pkg::uword_t uword
);
    import frgcd_pkg::*;

    always_comb
    begin
        unique case (addr)
            // wait for a transfer, capture it when it comes
            STEP_IDLE:     uword = '{OP_LOAD,       C_NO_IN,     EX_NOT_TAKEN, STEP_IDLE};
            STEP_CHK_BOTH: uword = '{OP_NOP,        C_BOTH_ZERO, EX_ALWAYS,    STEP_UNDEF};
            STEP_CHK_U:    uword = '{OP_G_FROM_V,   C_U_ZERO,    EX_TAKEN,     STEP_DIV_INIT};
            STEP_CHK_V:    uword = '{OP_G_FROM_U,   C_V_ZERO,    EX_TAKEN,     STEP_DIV_INIT};
            STEP_STRIP:    uword = '{OP_HALVE_BOTH, C_BOTH_EVEN, EX_TAKEN,     STEP_STRIP};
            STEP_ODD_U:    uword = '{OP_HALVE_U,    C_U_EVEN,    EX_TAKEN,     STEP_ODD_U};
            STEP_ODD_V:    uword = '{OP_HALVE_V,    C_V_EVEN,    EX_TAKEN,     STEP_ODD_V};
            STEP_SUB:      uword = '{OP_SUB,        C_SUB_MORE,  EX_ALWAYS,    STEP_ODD_V};
            STEP_G_SHIFT:  uword = '{OP_G_SHIFT,    C_ALWAYS,    EX_ALWAYS,    STEP_DIV_INIT};
            STEP_DIV_INIT: uword = '{OP_DIV_INIT,   C_ALWAYS,    EX_ALWAYS,    STEP_DIV_LOOP};
            STEP_DIV_LOOP: uword = '{OP_DIV_STEP,   C_DIV_MORE,  EX_ALWAYS,    STEP_DIV_LOOP};
            // hold until the result register is free
            STEP_EMIT:     uword = '{OP_EMIT,       C_OUT_BUSY,  EX_NOT_TAKEN, STEP_EMIT};
            STEP_RETURN:   uword = '{OP_NOP,        C_ALWAYS,    EX_ALWAYS,    STEP_IDLE};
            STEP_UNDEF:    uword = '{OP_UNDEF,      C_ALWAYS,    EX_ALWAYS,    STEP_EMIT};
            default:       uword = '{OP_NOP,        C_ALWAYS,    EX_ALWAYS,    STEP_IDLE};
        endcase
    end

endmodule

FILE: hdl/frgcd_datapath.sv
// Working registers, subtractor, shifter and two restoring divider lanes.
// Depends on frgcd_pkg; driven one operation per cycle by the sequencer.
module frgcd_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  frgcd_pkg::op_t        op,
    input  frgcd_pkg::word_t      in_numerator,
    input  frgcd_pkg::word_t      in_denominator,
    input  logic                  out_ready,
    output logic                  out_valid,
    output frgcd_pkg::word_t      out_numerator,
    output frgcd_pkg::word_t      out_denominator,
    output frgcd_pkg::word_t      out_divisor,
    output logic                  out_undefined,
    output frgcd_pkg::dp_status_t status
);
    import frgcd_pkg::*;

    word_t                 n_reg, d_reg;
    word_t                 u_reg, v_reg;
    word_t                 g_reg;
    logic [SHIFT_BITS-1:0] k_reg;
    word_t                 qn_reg, qd_reg;
    word_t                 rn_reg, rd_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic                  undef_reg;
    word_t                 res_n_reg, res_d_reg, res_g_reg;
    logic                  res_undef_reg;
    logic                  out_valid_reg;

    logic [WORD_BITS:0]    u_minus_v;
    logic                  u_gt_v;
    logic [WORD_BITS:0]    rn_shift, rd_shift;
    logic [WORD_BITS:0]    rn_diff, rd_diff;

    assign u_minus_v = {1'b0, u_reg} - {1'b0, v_reg};
    assign u_gt_v    = !u_minus_v[WORD_BITS] && (u_reg != v_reg);

    // one restoring step per lane: shift in the next dividend bit, try to subtract
    assign rn_shift = {rn_reg, qn_reg[WORD_BITS-1]};
    assign rd_shift = {rd_reg, qd_reg[WORD_BITS-1]};
    assign rn_diff  = rn_shift - {1'b0, g_reg};
    assign rd_diff  = rd_shift - {1'b0, g_reg};

    always_ff @(posedge clk)
    begin
        unique case (op)
            OP_LOAD:
            begin
                n_reg     <= in_numerator;
                d_reg     <= in_denominator;
                u_reg     <= in_numerator;
                v_reg     <= in_denominator;
                k_reg     <= '0;
                undef_reg <= 1'b0;
            end
            OP_G_FROM_U:   g_reg <= u_reg;
            OP_G_FROM_V:   g_reg <= v_reg;
            OP_HALVE_BOTH:
            begin
                u_reg <= u_reg >> 1;
                v_reg <= v_reg >> 1;
                k_reg <= k_reg + SHIFT_BITS'(1);
            end
            OP_HALVE_U:    u_reg <= u_reg >> 1;
            OP_HALVE_V:    v_reg <= v_reg >> 1;
            OP_SUB:
            begin
                if (u_gt_v)
                begin
                    u_reg <= v_reg;
                    v_reg <= u_minus_v[WORD_BITS-1:0];
                end
                else
                begin
                    v_reg <= v_reg - u_reg;
                end
            end
            OP_G_SHIFT:    g_reg <= u_reg << k_reg;
            OP_DIV_INIT:
            begin
                qn_reg  <= n_reg;
                qd_reg  <= d_reg;
                rn_reg  <= '0;
                rd_reg  <= '0;
                cnt_reg <= CNT_BITS'(WORD_BITS);
            end
            OP_DIV_STEP:
            begin
                // the remainder stays below the divisor, so its top bit is always clear
                rn_reg  <= rn_diff[WORD_BITS] ? rn_shift[WORD_BITS-1:0]
                                              : rn_diff[WORD_BITS-1:0];
                rd_reg  <= rd_diff[WORD_BITS] ? rd_shift[WORD_BITS-1:0]
                                              : rd_diff[WORD_BITS-1:0];
                qn_reg  <= {qn_reg[WORD_BITS-2:0], !rn_diff[WORD_BITS]};
                qd_reg  <= {qd_reg[WORD_BITS-2:0], !rd_diff[WORD_BITS]};
                cnt_reg <= cnt_reg - CNT_BITS'(1);
            end
            OP_UNDEF:
            begin
                qn_reg    <= '0;
                qd_reg    <= '0;
                g_reg     <= '0;
                undef_reg <= 1'b1;
            end
            OP_EMIT:
            begin
                res_n_reg     <= qn_reg;
                res_d_reg     <= qd_reg;
                res_g_reg     <= g_reg;
                res_undef_reg <= undef_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (op == OP_EMIT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_numerator   = res_n_reg;
    assign out_denominator = res_d_reg;
    assign out_divisor     = res_g_reg;
    assign out_undefined   = res_undef_reg;

    assign status.both_zero = (u_reg == '0) && (v_reg == '0);
    assign status.u_zero    = (u_reg == '0);
    assign status.v_zero    = (v_reg == '0);
    assign status.both_even = !u_reg[0] && !v_reg[0];
    assign status.u_even    = !u_reg[0];
    assign status.v_even    = !v_reg[0];
    assign status.sub_more  = (u_reg != v_reg);
    assign status.div_more  = (cnt_reg != CNT_BITS'(1));
    assign status.out_busy  = out_valid_reg && !out_ready;

endmodule

FILE: hdl/fraction_reduce_binary_gcd_unit.sv
// Fraction reducer: binary GCD, then both parts divided by it, one item at a time.
// Both parts zero lead to the undefined result; with one zero part the GCD is the other
// part and only the divider runs; otherwise the GCD subtract/halve loop runs first.
// A held result stalls the result load; the return step then leads back to the idle step,
// which takes the next item. Reset clears the step counter and result valid.
module fraction_reduce_binary_gcd_unit (
    input  logic       clk,
    input  logic       rst_n,
    frgcd_in_if.sink   in_ch,
    frgcd_out_if.source out_ch
);
    import frgcd_pkg::*;

    step_t      pc_reg, pc_next;
    uword_t     uword;
    dp_status_t status;
    logic       cond_hit;
    logic       fire;
    op_t        op_issue;

    frgcd_rom u_rom (
        .addr  (pc_reg),
        .uword (uword)
    );

    always_comb
    begin
        case (uword.cond)
            C_ALWAYS:    cond_hit = 1'b1;
            C_NO_IN:     cond_hit = !in_ch.valid;
            C_BOTH_ZERO: cond_hit = status.both_zero;
            C_U_ZERO:    cond_hit = status.u_zero;
            C_V_ZERO:    cond_hit = status.v_zero;
            C_BOTH_EVEN: cond_hit = status.both_even;
            C_U_EVEN:    cond_hit = status.u_even;
            C_V_EVEN:    cond_hit = status.v_even;
            C_SUB_MORE:  cond_hit = status.sub_more;
            C_DIV_MORE:  cond_hit = status.div_more;
            C_OUT_BUSY:  cond_hit = status.out_busy;
            default:     cond_hit = 1'b1;
        endcase
    end

    always_comb
    begin
        case (uword.exec)
            EX_TAKEN:     fire = cond_hit;
            EX_NOT_TAKEN: fire = !cond_hit;
            default:      fire = 1'b1;
        endcase
        op_issue = fire ? uword.op : OP_NOP;
        pc_next  = cond_hit ? uword.target : pc_reg + STEP_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign in_ch.ready = (pc_reg == STEP_IDLE);

    frgcd_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .op              (op_issue),
        .in_numerator    (in_ch.numerator),
        .in_denominator  (in_ch.denominator),
        .out_ready       (out_ch.ready),
        .out_valid       (out_ch.valid),
        .out_numerator   (out_ch.reduced_numerator),
        .out_denominator (out_ch.reduced_denominator),
        .out_divisor     (out_ch.common_divisor),
        .out_undefined   (out_ch.undefined_flag),
        .status          (status)
    );

endmodule
